// ===== sv/cmc_pkg.sv =====
// ----------------------------------------------------------------------------
// cmc_pkg: shared types and date arithmetic for the calendar minute counter
// Field widths, command and error codes, and the calendar helper functions
// (leap year, month length, Julian day number, weekday).
// ----------------------------------------------------------------------------
package cmc_pkg;

  localparam int YEAR_W      = 12;
  localparam int MONTH_W     = 4;
  localparam int DAY_W       = 5;
  localparam int HOUR_W      = 5;
  localparam int MIN_W       = 6;
  localparam int JDN_W       = 22;
  localparam int WDAY_W      = 3;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 88;

  localparam logic [YEAR_W-1:0] YEAR_RESET = 12'd2024;
  localparam logic [YEAR_W-1:0] YEAR_MAX   = 12'd4095;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_SET  = 2'd1,
    CMD_CMP  = 2'd2,
    CMD_DAY  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ERR_OK     = 3'd0,
    ERR_YEAR   = 3'd1,
    ERR_MONTH  = 3'd2,
    ERR_DAY    = 3'd3,
    ERR_HOUR   = 3'd4,
    ERR_MINUTE = 3'd5
  } err_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // Incoming transaction after the input register
  typedef struct packed {
    cmd_t              cmd;
    date_t             date;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
  } in_item_t;

  // Result of the state update stage
  typedef struct packed {
    date_t             cur_date;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    err_t              err;
    logic              cmp;
    date_t             in_date;
  } step_item_t;

  // Result of the day number stage
  typedef struct packed {
    date_t             cur_date;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    err_t              err;
    logic              cmp;
    logic [JDN_W-1:0]  jdn_cur;
    logic [JDN_W-1:0]  jdn_in;
  } jdn_item_t;

  // floor(x / 100) for x up to 8895, by reciprocal multiply (5243 / 2^19)
  function automatic logic [6:0] div100(input logic [13:0] x);
    logic [26:0] p;
    p = {13'd0, x} * 27'd5243;
    return p[25:19];
  endfunction

  // Gregorian leap year; year zero counts as leap
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [6:0]  q;
    logic [13:0] back;
    logic        cent;
    q    = div100({2'b00, y});
    back = 14'({7'd0, q} * 14'd100);
    cent = (back == {2'b00, y});
    return ((y[1:0] == 2'b00) && !cent) || (cent && (q[1:0] == 2'b00));
  endfunction

  // Days in a month; zero for a month outside 1..12
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // (153 * mm + 2) / 5 with the March-based month index mm
  function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [8:0] ofs;
    case (m)
      4'd0:    ofs = 9'd275;
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      4'd13:   ofs = 9'd306;
      4'd14:   ofs = 9'd337;
      default: ofs = 9'd367;
    endcase
    return ofs;
  endfunction

  // Julian day number; the true value is positive and below 2^22
  function automatic logic [JDN_W-1:0] julian_day(input date_t dt);
    logic        early;
    logic [13:0] yy;
    logic [6:0]  q;
    early = (dt.month <= 4'd2);
    yy    = {2'b00, dt.year} + 14'd4800 - {13'd0, early};
    q     = div100(yy);
    return {17'd0, dt.day} + {13'd0, month_offset(dt.month)}
         + ({8'd0, yy} * 22'd365) + {10'd0, yy[13:2]}
         - {15'd0, q} + {17'd0, q[6:2]} - 22'd32045;
  endfunction

  // x mod 7 by folding octal digits (8 is 1 mod 7)
  function automatic logic [WDAY_W-1:0] mod7(input logic [22:0] x);
    logic [23:0] xe;
    logic [5:0]  s;
    logic [3:0]  t;
    logic [2:0]  u;
    xe = {1'b0, x};
    s  = '0;
    for (int i = 0; i < 8; i++) s = s + {3'd0, xe[3*i +: 3]};
    t = {1'b0, s[5:3]} + {1'b0, s[2:0]};
    u = t[2:0] + {2'd0, t[3]};
    return (u == 3'd7) ? 3'd0 : u;
  endfunction

endpackage

// ===== sv/cmc_step.sv =====
// ----------------------------------------------------------------------------
// cmc_step: date/time state and update stage
// Holds the stored date and time and the reference year, applies tick,
// advance, set (with validation) and compare, and registers the outcome.
// ----------------------------------------------------------------------------
module cmc_step (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [cmc_pkg::YEAR_W-1:0]   cfg_wr_data,
  input  logic                         in_valid,
  input  cmc_pkg::in_item_t            in_item,
  output logic                         in_ready,
  output logic                         out_valid,
  output cmc_pkg::step_item_t          out_item,
  input  logic                         out_ready
);
  import cmc_pkg::*;

  logic [YEAR_W-1:0]  ref_year_r;
  logic [YEAR_W-1:0]  year_r,   year_nxt;
  logic [MONTH_W-1:0] month_r,  month_nxt;
  logic [DAY_W-1:0]   day_r,    day_nxt;
  logic [HOUR_W-1:0]  hour_r,   hour_nxt;
  logic [MIN_W-1:0]   minute_r, minute_nxt;
  logic               valid_r;
  step_item_t         item_r,   item_nxt;

  logic               take;
  logic [DAY_W-1:0]   cur_mlen;
  logic [MIN_W:0]     min_inc;
  logic               min_wrap;
  logic [HOUR_W:0]    hour_inc;
  logic               hour_wrap;
  logic [DAY_W:0]     day_inc;
  logic               day_wrap;
  logic [MONTH_W:0]   month_inc;
  logic               month_wrap;
  logic [YEAR_W-1:0]  year_roll;
  logic               day_step;
  logic [YEAR_W:0]    ry_ext, iy_ext;
  logic [DAY_W-1:0]   in_mlen;
  err_t               chk;

  assign in_ready  = !valid_r || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  // Minute / hour / day carry chain from the stored values
  assign cur_mlen   = month_len(month_r, is_leap(year_r));
  assign min_inc    = {1'b0, minute_r} + 7'd1;
  assign min_wrap   = (min_inc > 7'd59);
  assign hour_inc   = {1'b0, hour_r} + {5'd0, min_wrap};
  assign hour_wrap  = (hour_inc > 6'd23);
  assign day_inc    = {1'b0, day_r} + 6'd1;
  assign day_wrap   = (day_inc > {1'b0, cur_mlen});
  assign month_inc  = {1'b0, month_r} + {4'd0, day_wrap};
  assign month_wrap = (month_inc > 5'd12);
  assign year_roll  = (year_r == YEAR_MAX) ? 12'd1 : year_r + 12'd1;

  // Set validation, first failing check wins
  assign ry_ext  = {1'b0, ref_year_r};
  assign iy_ext  = {1'b0, in_item.date.year};
  assign in_mlen = month_len(in_item.date.month, is_leap(in_item.date.year));

  always_comb begin
    if ((iy_ext + 13'd1 < ry_ext) || (iy_ext > ry_ext + 13'd1)) begin
      chk = ERR_YEAR;
    end else if ((in_item.date.month == 4'd0) || (in_item.date.month > 4'd12)) begin
      chk = ERR_MONTH;
    end else if ((in_item.date.day == 5'd0) || (in_item.date.day > in_mlen)) begin
      chk = ERR_DAY;
    end else if (in_item.hour > 5'd23) begin
      chk = ERR_HOUR;
    end else if (in_item.minute > 6'd59) begin
      chk = ERR_MINUTE;
    end else begin
      chk = ERR_OK;
    end
  end

  // Next state per command
  always_comb begin
    year_nxt   = year_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    day_step   = 1'b0;
    unique case (in_item.cmd)
      CMD_TICK: begin
        minute_nxt = min_wrap ? '0 : min_inc[MIN_W-1:0];
        hour_nxt   = hour_wrap ? '0 : hour_inc[HOUR_W-1:0];
        day_step   = hour_wrap;
      end
      CMD_SET: begin
        if (chk == ERR_OK) begin
          year_nxt   = in_item.date.year;
          month_nxt  = in_item.date.month;
          day_nxt    = in_item.date.day;
          hour_nxt   = in_item.hour;
          minute_nxt = in_item.minute;
        end
      end
      CMD_CMP: begin
      end
      CMD_DAY: begin
        day_step = 1'b1;
      end
    endcase
    if (day_step) begin
      day_nxt   = day_wrap ? 5'd1 : day_inc[DAY_W-1:0];
      month_nxt = month_wrap ? 4'd1 : month_inc[MONTH_W-1:0];
      if (month_wrap) year_nxt = year_roll;
    end
  end

  // Stage payload
  always_comb begin
    item_nxt.cur_date.year  = year_nxt;
    item_nxt.cur_date.month = month_nxt;
    item_nxt.cur_date.day   = day_nxt;
    item_nxt.hour           = hour_nxt;
    item_nxt.minute         = minute_nxt;
    item_nxt.err            = (in_item.cmd == CMD_SET) ? chk : ERR_OK;
    item_nxt.cmp            = (in_item.cmd == CMD_CMP);
    item_nxt.in_date        = in_item.date;
  end

  // Control and stored state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_year_r <= YEAR_RESET;
      year_r     <= YEAR_RESET;
      month_r    <= 4'd1;
      day_r      <= 5'd1;
      hour_r     <= '0;
      minute_r   <= '0;
      valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) ref_year_r <= cfg_wr_data;
      if (take) begin
        year_r   <= year_nxt;
        month_r  <= month_nxt;
        day_r    <= day_nxt;
        hour_r   <= hour_nxt;
        minute_r <= minute_nxt;
      end
      if (in_ready) valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) item_r <= item_nxt;
  end

endmodule

// ===== sv/cmc_jdn.sv =====
// ----------------------------------------------------------------------------
// cmc_jdn: day number stage
// Computes the Julian day numbers of the stored date and of the given date.
// ----------------------------------------------------------------------------
module cmc_jdn (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  cmc_pkg::step_item_t  in_item,
  output logic                 in_ready,
  output logic                 out_valid,
  output cmc_pkg::jdn_item_t   out_item,
  input  logic                 out_ready
);
  import cmc_pkg::*;

  logic      valid_r;
  jdn_item_t item_r, item_nxt;
  logic      take;

  assign in_ready  = !valid_r || out_ready;
  assign take      = in_valid && in_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  // Both day numbers in parallel
  always_comb begin
    item_nxt.cur_date = in_item.cur_date;
    item_nxt.hour     = in_item.hour;
    item_nxt.minute   = in_item.minute;
    item_nxt.err      = in_item.err;
    item_nxt.cmp      = in_item.cmp;
    item_nxt.jdn_cur  = julian_day(in_item.cur_date);
    item_nxt.jdn_in   = julian_day(in_item.in_date);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) item_r <= item_nxt;
  end

endmodule

// ===== sv/calendar_minute_counter.sv =====
// ----------------------------------------------------------------------------
// calendar_minute_counter: Gregorian date/time counter with day numbers
// Input register, state update stage, day number stage and result register.
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------------
//   cfg_    | in  | cfg_wr_en            | cfg_wr_data: reference year
//   in_     | in  | in_tvalid/in_tready  | in_tuser: command; in_tdata: date
//   out_    | out | out_tvalid/out_tready| out_tdata: date, day no., flags
//
// A transaction passes the input, update, day number and result registers in
// order; one transaction per cycle is sustained while out_tready stays high.
// Every stage has its own valid bit and takes new data while the next stage
// drains, so in_tready falls only when all four stages are full and stalled.
// Reset loads 2024-01-01 00:00 and reference year 2024 and empties stages.
// A reference year write applies to sets taken by the update stage after it.
// ----------------------------------------------------------------------------
module calendar_minute_counter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [cmc_pkg::YEAR_W-1:0]        cfg_wr_data,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: in_year[11:0], in_month[15:12], in_day[20:16], in_hour[25:21],
  //           in_minute[31:26]
  input  logic [cmc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // in_tuser: command[1:0]
  input  logic [cmc_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: cur_year[11:0], cur_month[15:12], cur_day[20:16],
  //            cur_hour[25:21], cur_minute[31:26], day_number[53:32],
  //            weekday[56:54], error_code[59:57], day_difference[81:60],
  //            zero fill[87:82]
  output logic [cmc_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import cmc_pkg::*;

  logic       in_valid_r;
  in_item_t   in_item_r, in_item_nxt;
  logic       step_ready, step_valid;
  step_item_t step_item;
  logic       jdn_ready, jdn_valid;
  jdn_item_t  jdn_item;
  logic       out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic       out_stage_ready;
  logic [WDAY_W-1:0] weekday;
  logic [JDN_W-1:0]  diff;

  // Input register
  assign in_tready = !in_valid_r || step_ready;

  always_comb begin
    in_item_nxt.cmd        = cmd_t'(in_tuser);
    in_item_nxt.date.year  = in_tdata[11:0];
    in_item_nxt.date.month = in_tdata[15:12];
    in_item_nxt.date.day   = in_tdata[20:16];
    in_item_nxt.hour       = in_tdata[25:21];
    in_item_nxt.minute     = in_tdata[31:26];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) in_item_r <= in_item_nxt;
  end

  // State update stage
  cmc_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid_r),
    .in_item     (in_item_r),
    .in_ready    (step_ready),
    .out_valid   (step_valid),
    .out_item    (step_item),
    .out_ready   (jdn_ready)
  );

  // Day number stage
  cmc_jdn u_jdn (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (step_valid),
    .in_item   (step_item),
    .in_ready  (jdn_ready),
    .out_valid (jdn_valid),
    .out_item  (jdn_item),
    .out_ready (out_stage_ready)
  );

  // Result register: weekday, difference, packing
  assign out_stage_ready = !out_valid_r || out_tready;
  assign weekday = mod7({1'b0, jdn_item.jdn_cur} + 23'd1);
  assign diff    = jdn_item.cmp ? (jdn_item.jdn_cur - jdn_item.jdn_in) : '0;

  assign out_tdata_nxt = {6'd0, diff, jdn_item.err, weekday, jdn_item.jdn_cur,
                          jdn_item.minute, jdn_item.hour, jdn_item.cur_date.day,
                          jdn_item.cur_date.month, jdn_item.cur_date.year};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_stage_ready) begin
      out_valid_r <= jdn_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (jdn_valid && out_stage_ready) out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== sv/cmc_checker.sv =====
// ----------------------------------------------------------------------------
// cmc_checker: result channel checks for the calendar minute counter
// Watches the top-level result port and flags held-data, range and
// consistency violations.
// ----------------------------------------------------------------------------
module cmc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [cmc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cmc_pkg::*;

  logic [MONTH_W-1:0] chk_month;
  logic [DAY_W-1:0]   chk_day;
  logic [HOUR_W-1:0]  chk_hour;
  logic [MIN_W-1:0]   chk_minute;
  logic [WDAY_W-1:0]  chk_wday;
  logic [2:0]         chk_err;
  logic [JDN_W-1:0]   chk_diff;

  assign chk_month  = out_tdata[15:12];
  assign chk_day    = out_tdata[20:16];
  assign chk_hour   = out_tdata[25:21];
  assign chk_minute = out_tdata[31:26];
  assign chk_wday   = out_tdata[56:54];
  assign chk_err    = out_tdata[59:57];
  assign chk_diff   = out_tdata[81:60];

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Stored date and time always legal
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (chk_month >= 4'd1) && (chk_month <= 4'd12) && (chk_day >= 5'd1)
                   && (chk_hour <= 5'd23) && (chk_minute <= 6'd59))
    else $error("stored date or time out of range");

  // Weekday and error code within their codes
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (chk_wday <= 3'd6) && (chk_err <= ERR_MINUTE))
    else $error("weekday or error code out of range");

  // A set error never comes with a day difference
  a_err_diff: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (chk_err != ERR_OK) |-> (chk_diff == '0))
    else $error("error flagged together with a day difference");

endmodule

bind calendar_minute_counter cmc_checker u_cmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== test/calendar_minute_counter_test.sv =====
// ----------------------------------------------------------------------------
// calendar_minute_counter_test: self-checking bench for the calendar counter
// Drives tick, set, compare and advance transactions over the input stream,
// tracks the expected date, day number and flags in a scoreboard, and checks
// every result transaction field by field. Runs several reference years and
// idle/stall patterns on both stream sides.
// ----------------------------------------------------------------------------
module calendar_minute_counter_test;
  import cmc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  // Result layout, lowest field last
  typedef struct packed {
    logic [5:0]  fill;
    logic [21:0] day_difference;
    err_t        error_code;
    logic [2:0]  weekday;
    logic [21:0] day_number;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } calendar_result_t;

  // Tracks the stored date/time and the results it should produce
  class calendar_tracker;
    logic [11:0] ref_year;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    calendar_result_t pending_readings[$];
    int errors;

    function new();
      ref_year = YEAR_RESET;
      year     = YEAR_RESET;
      month    = 4'd1;
      day      = 5'd1;
      hour     = '0;
      minute   = '0;
      errors   = 0;
    endfunction

    static function bit leap_year(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int month_days(int y, int m);
      case (m)
        2:           return leap_year(y) ? 29 : 28;
        4, 6, 9, 11: return 30;
        default:     return 31;
      endcase
    endfunction

    // Julian day number, any month 0..15 and day 0..31
    static function int day_count(int y, int m, int d);
      int a;
      int yy;
      int mm;
      a  = (m <= 2) ? 1 : 0;
      yy = y + 4800 - a;
      mm = m + 12 * a - 3;
      return d + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
    endfunction

    // Day 31 plus one does not fit the day field, so compare before storing
    function void step_day();
      if (month < 4'd1 || month > 4'd12 || int'(day) + 1 > month_days(year, month)) begin
        day   = 5'd1;
        month = month + 4'd1;
      end else begin
        day = day + 5'd1;
      end
      if (month > 4'd12) begin
        month = 4'd1;
        year  = (year == YEAR_MAX) ? 12'd1 : year + 12'd1;
      end
    endfunction

    function void step_minute();
      minute = minute + 6'd1;
      if (minute > 6'd59) begin
        minute = '0;
        hour   = hour + 5'd1;
      end
      if (hour > 5'd23) begin
        hour = '0;
        step_day();
      end
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction

    // Accepted input transaction: update the date and queue the result
    function void note_command(cmd_t cmd, logic [31:0] fields);
      int   y;
      int   m;
      int   d;
      int   h;
      int   mi;
      int   jdn;
      err_t err;
      calendar_result_t r;
      y   = fields[11:0];
      m   = fields[15:12];
      d   = fields[20:16];
      h   = fields[25:21];
      mi  = fields[31:26];
      err = ERR_OK;
      case (cmd)
        CMD_TICK: step_minute();
        CMD_DAY:  step_day();
        CMD_SET: begin
          if (y < int'(ref_year) - 1 || y > int'(ref_year) + 1) err = ERR_YEAR;
          else if (m < 1 || m > 12)                          err = ERR_MONTH;
          else if (d < 1 || d > month_days(y, m))            err = ERR_DAY;
          else if (h > 23)                                    err = ERR_HOUR;
          else if (mi > 59)                                   err = ERR_MINUTE;
          if (err == ERR_OK) begin
            year   = 12'(y);
            month  = 4'(m);
            day    = 5'(d);
            hour   = 5'(h);
            minute = 6'(mi);
          end
        end
        default: ;
      endcase
      jdn              = day_count(year, month, day);
      r.fill           = '0;
      r.year           = year;
      r.month          = month;
      r.day            = day;
      r.hour           = hour;
      r.minute         = minute;
      r.day_number     = 22'(jdn);
      r.weekday        = 3'((jdn + 1) % 7);
      r.error_code     = err;
      r.day_difference = (cmd == CMD_CMP) ? 22'(jdn - day_count(y, m, d)) : '0;
      pending_readings.push_back(r);
    endfunction

    // Accepted result transaction: compare against the oldest expectation
    function void check_reading(logic [87:0] tdata);
      string names[10] = '{"year", "month", "day", "hour", "minute", "day_number",
                           "weekday", "error_code", "day_difference", "fill"};
      int    widths[10] = '{12, 4, 5, 5, 6, 22, 3, 3, 22, 6};
      logic [87:0] want;
      logic [87:0] mask;
      int lsb;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, tdata);
        errors++;
        return;
      end
      want = pending_readings.pop_front();
      lsb  = 0;
      for (int i = 0; i < 10; i++) begin
        mask = (88'd1 << widths[i]) - 88'd1;
        if (((want >> lsb) & mask) !== ((tdata >> lsb) & mask)) begin
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, names[i],
                   (want >> lsb) & mask, (tdata >> lsb) & mask);
          errors++;
        end
        lsb += widths[i];
      end
    endfunction
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [11:0] cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata    = '0;
  logic [1:0]  in_tuser    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [87:0] out_tdata;

  calendar_tracker tracker = new();
  int idle_pct   = 0;
  int stall_pct  = 0;
  int cur_ref    = 2024;
  int cycle_count = 0;

  calendar_minute_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Monitor: register writes, accepted inputs, accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) tracker.ref_year = cfg_wr_data;
      if (in_tvalid && in_tready) tracker.note_command(cmd_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready) tracker.check_reading(out_tdata);
    end
  end

  task automatic send_item(input cmd_t cmd, input int y, input int m, input int d,
                           input int h, input int mi);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'(mi), 5'(h), 5'(d), 4'(m), 12'(y)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Let the monitor note the last accepted transaction before checking pending results
  task automatic drain();
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Only while idle: stop sending, let results drain, then write
  task automatic write_reference_year(input int value);
    in_tvalid <= 1'b0;
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 12'(value);
    cur_ref     = value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // A date and time that passes the set check, biased to day/hour/minute ends
  task automatic pick_valid_date(output int y, output int m, output int d,
                                 output int h, output int mi);
    int lo;
    int hi;
    int len;
    lo  = cur_ref - 1;
    hi  = (cur_ref >= 4095) ? 4095 : cur_ref + 1;
    y   = $urandom_range(hi, lo);
    m   = $urandom_range(1, 12);
    len = calendar_tracker::month_days(y, m);
    d   = $urandom_range(0, 1) ? len : $urandom_range(1, len);
    h   = $urandom_range(0, 1) ? 23 : $urandom_range(0, 23);
    mi  = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
  endtask

  task automatic send_random_item();
    int kind;
    int y;
    int m;
    int d;
    int h;
    int mi;
    int len;
    kind = $urandom_range(0, 99);
    pick_valid_date(y, m, d, h, mi);
    if (kind < 22) begin
      send_item(CMD_TICK, $urandom_range(1, 4095), $urandom_range(0, 15),
                $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63));
    end else if (kind < 34) begin
      send_item(CMD_DAY, $urandom_range(1, 4095), $urandom_range(0, 15),
                $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63));
    end else if (kind < 56) begin
      send_item(CMD_SET, y, m, d, h, mi);
    end else if (kind < 72) begin
      // Broken set, each case aimed at one failing check
      case ($urandom_range(1, 5))
        1: begin
          y = $urandom_range(0, 1) ? cur_ref + 2 : cur_ref - 2;
          while (y < 1 || y > 4095 || (y >= cur_ref - 1 && y <= cur_ref + 1))
            y = $urandom_range(1, 4095);
          m  = $urandom_range(0, 15);
          d  = $urandom_range(0, 31);
          h  = $urandom_range(0, 31);
          mi = $urandom_range(0, 63);
        end
        2: begin
          m = $urandom_range(0, 3);
          if (m != 0) m += 12;
          d  = $urandom_range(0, 31);
          h  = $urandom_range(0, 31);
          mi = $urandom_range(0, 63);
        end
        3: begin
          len = calendar_tracker::month_days(y, m);
          d   = ($urandom_range(0, 1) || len == 31) ? 0 : $urandom_range(len + 1, 31);
          h   = $urandom_range(0, 31);
          mi  = $urandom_range(0, 63);
        end
        4: begin
          h  = $urandom_range(24, 31);
          mi = $urandom_range(0, 63);
        end
        default: mi = $urandom_range(60, 63);
      endcase
      send_item(CMD_SET, y, m, d, h, mi);
    end else if (kind < 80) begin
      // Compare against a nearby valid date
      send_item(CMD_CMP, y, m, d, $urandom_range(0, 31), $urandom_range(0, 63));
    end else if (kind < 90) begin
      send_item(CMD_CMP, $urandom_range(1, 4095), $urandom_range(0, 15),
                $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63));
    end else begin
      // Noise over the full field ranges
      send_item(cmd_t'($urandom_range(0, 3)), $urandom_range(1, 4095),
                $urandom_range(0, 15), $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 63));
    end
  endtask

  task automatic run_phase(input int ref_year, input int mode, input int count);
    int hi;
    write_reference_year(ref_year);
    case (mode)
      1:       begin idle_pct = 78; stall_pct = 0;  end
      2:       begin idle_pct = 0;  stall_pct = 78; end
      3:       begin idle_pct = 21; stall_pct = 21; end
      default: begin idle_pct = 0;  stall_pct = 0;  end
    endcase
    // Leap days around the reference year and the year-end rollover
    hi = (ref_year >= 4095) ? 4095 : ref_year + 1;
    send_item(CMD_SET, ref_year, 2, 29, 12, 0);
    send_item(CMD_SET, ref_year - 1, 2, 29, 12, 0);
    send_item(CMD_SET, hi, 12, 31, 23, 59);
    send_item(CMD_TICK, 0, 0, 0, 0, 0);
    send_item(CMD_SET, hi, 12, 31, 5, 30);
    send_item(CMD_DAY, 0, 0, 0, 0, 0);
    repeat (count) send_random_item();
  endtask

  initial begin
    int ref_years[8];
    ref_years = '{2024, 1, 4095, 1900, 2000, 0, 4094, 0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, field extremes, every error, rollovers
    write_reference_year(2024);
    send_item(CMD_TICK, 0, 0, 0, 0, 0);
    send_item(CMD_DAY, 0, 0, 0, 0, 0);
    send_item(CMD_CMP, 2024, 1, 2, 0, 0);
    send_item(CMD_CMP, 1, 0, 0, 31, 63);
    send_item(CMD_CMP, 4095, 15, 31, 0, 0);
    send_item(CMD_SET, 2026, 6, 15, 0, 0);
    send_item(CMD_SET, 2022, 6, 15, 0, 0);
    send_item(CMD_SET, 2024, 0, 15, 0, 0);
    send_item(CMD_SET, 2024, 15, 31, 31, 63);
    send_item(CMD_SET, 2025, 2, 29, 0, 0);
    send_item(CMD_SET, 2024, 4, 31, 0, 0);
    send_item(CMD_SET, 2024, 1, 0, 0, 0);
    send_item(CMD_SET, 2024, 2, 29, 24, 0);
    send_item(CMD_SET, 2024, 2, 29, 23, 60);
    send_item(CMD_SET, 2024, 2, 29, 23, 59);
    send_item(CMD_TICK, 0, 0, 0, 0, 0);
    send_item(CMD_SET, 2023, 2, 28, 23, 59);
    send_item(CMD_TICK, 0, 0, 0, 0, 0);
    send_item(CMD_SET, 2025, 12, 31, 23, 59);
    send_item(CMD_TICK, 0, 0, 0, 0, 0);
    send_item(CMD_SET, 2024, 12, 31, 10, 0);
    send_item(CMD_DAY, 0, 0, 0, 0, 0);
    send_item(CMD_SET, 2024, 4, 30, 23, 59);
    send_item(CMD_DAY, 0, 0, 0, 0, 0);
    send_item(CMD_CMP, 2024, 5, 1, 0, 0);

    // Random phases over reference years and idle patterns
    for (int p = 0; p < 8; p++) begin
      run_phase((ref_years[p] == 0) ? $urandom_range(2, 4094) : ref_years[p], p % 4, 42);
    end

    in_tvalid <= 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/cmc_pkg.sv
sv/cmc_step.sv
sv/cmc_jdn.sv
sv/calendar_minute_counter.sv
sv/cmc_checker.sv
test/calendar_minute_counter_test.sv
